// File: hw/rtl/urs_pkg.sv
package urs_pkg;

	localparam int BYTE_W     = 8;
	localparam int COEFF_W    = 12;
	localparam int INDEX_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int MOD_W      = 13;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(1024);
	localparam logic [MOD_W-1:0]   MODULUS_RESET = MOD_W'(3329);
	localparam logic [COUNT_W-1:0] TARGET_RESET  = COUNT_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS = 8'd0,
		REG_TARGET  = 8'd1
	} urs_reg_t;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} urs_phase_t;

	typedef enum logic {
		CMD_DATA    = 1'b0,
		CMD_RESTART = 1'b1
	} urs_cmd_t;

	typedef struct packed {
		logic [MOD_W-1:0]   modulus;
		logic [COUNT_W-1:0] target;
	} urs_cfg_t;

	typedef struct packed {
		logic               vld;
		logic [COEFF_W-1:0] coefficient;
		logic [INDEX_W-1:0] coeff_index;
		logic               final_coeff;
	} urs_res_t;

	typedef struct packed {
		urs_res_t lo;
		urs_res_t hi;
	} urs_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} urs_fifo_status_t;

endpackage

// File: hw/rtl/urs_ifs.sv
interface urs_in_if;
	import urs_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [BYTE_W-1:0] data_byte;
	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface urs_out_if;
	import urs_pkg::*;
	logic               valid;
	logic               ready;
	logic [COEFF_W-1:0] coefficient;
	logic [INDEX_W-1:0] coeff_index;
	logic               final_coeff;
	logic               run_last;
	modport source (output valid, output coefficient, output coeff_index,
		output final_coeff, output run_last, input ready);
	modport sink (input valid, input coefficient, input coeff_index,
		input final_coeff, input run_last, output ready);
endinterface

interface urs_cfg_if;
	import urs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/urs_front.sv
module urs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	urs_in_if.sink                    smp_in,
	input  urs_pkg::urs_cfg_t         cfg,
	input  urs_pkg::urs_fifo_status_t fifo_st,
	output logic                      push,
	output urs_pkg::urs_entry_t       push_entry
);
	import urs_pkg::*;

	urs_phase_t         phase_q, phase_d;
	logic [BYTE_W-1:0]  b0_q, b0_d, b1_q, b1_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d, cnt1;
	logic [COEFF_W-1:0] c0, c1;
	logic               acc, ok0, ok1;

	assign smp_in.ready = !fifo_st.full;
	assign acc = smp_in.valid && smp_in.ready;

	// candidates of the group closed by the current byte
	assign c0   = {b1_q[3:0], b0_q};
	assign c1   = {smp_in.data_byte, b1_q[7:4]};
	assign ok0  = {1'b0, c0} < cfg.modulus;
	assign cnt1 = cnt_q + COUNT_W'(ok0);
	assign ok1  = ({1'b0, c1} < cfg.modulus) && (cnt1 < cfg.target);

	always_comb begin
		phase_d    = phase_q;
		b0_d       = b0_q;
		b1_d       = b1_q;
		cnt_d      = cnt_q;
		push       = 1'b0;
		push_entry.lo.vld         = ok0;
		push_entry.lo.coefficient = c0;
		push_entry.lo.coeff_index = cnt_q[INDEX_W-1:0];
		push_entry.lo.final_coeff = (cnt_q + COUNT_W'(1)) == cfg.target;
		push_entry.hi.vld         = ok1;
		push_entry.hi.coefficient = c1;
		push_entry.hi.coeff_index = cnt1[INDEX_W-1:0];
		push_entry.hi.final_coeff = (cnt1 + COUNT_W'(1)) == cfg.target;
		if (acc) begin
			if (smp_in.cmd == CMD_RESTART) begin
				cnt_d   = '0;
				phase_d = PH_FIRST;
			end else if (cnt_q < cfg.target) begin
				case (phase_q)
					PH_SECOND: begin
						b1_d    = smp_in.data_byte;
						phase_d = PH_THIRD;
					end
					PH_THIRD: begin
						phase_d = PH_FIRST;
						cnt_d   = cnt1 + COUNT_W'(ok1);
						push    = ok0 || ok1;
					end
					default: begin
						b0_d    = smp_in.data_byte;
						phase_d = PH_SECOND;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		b0_q <= b0_d;
		b1_q <= b1_d;
	end

endmodule

// File: hw/rtl/urs_fifo.sv
module urs_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  urs_pkg::urs_entry_t       push_entry,
	input  logic                      pop,
	output urs_pkg::urs_entry_t       pop_entry,
	output urs_pkg::urs_fifo_status_t status
);
	import urs_pkg::*;

	urs_entry_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   fill_q;
	logic               do_push, do_pop;

	assign status.full  = fill_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign status.empty = fill_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_entry    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + FIFO_AW'(1);
			if (do_pop)  rptr_q <= rptr_q + FIFO_AW'(1);
			fill_q <= fill_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_entry;
	end

endmodule

// File: hw/rtl/urs_back.sv
module urs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  urs_pkg::urs_entry_t       pop_entry,
	input  urs_pkg::urs_fifo_status_t fifo_st,
	output logic                      pop,
	urs_out_if.source                 smp_out
);
	import urs_pkg::*;

	urs_entry_t hold_q;
	logic       lo_q, hi_q;
	logic       take, last, done, load;
	urs_res_t   cur;

	assign cur  = lo_q ? hold_q.lo : hold_q.hi;
	assign last = lo_q ? !hi_q : 1'b1;
	assign take = smp_out.valid && smp_out.ready;
	assign done = take && last;
	assign load = !smp_out.valid || done;
	assign pop  = load && !fifo_st.empty;

	assign smp_out.valid       = lo_q || hi_q;
	assign smp_out.coefficient = cur.coefficient;
	assign smp_out.coeff_index = cur.coeff_index;
	assign smp_out.final_coeff = cur.final_coeff;
	assign smp_out.run_last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= 1'b0;
			hi_q <= 1'b0;
		end else if (load) begin
			lo_q <= pop && pop_entry.lo.vld;
			hi_q <= pop && pop_entry.hi.vld;
		end else if (take) begin
			lo_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) hold_q <= pop_entry;
	end

endmodule

// File: hw/rtl/uniform_rejection_sampler_12bit_core.sv
// a coefficient is written into the queue by the request that closes its byte group,
// then into the output stage; a group's second follows once its first is taken
// throughput: one request per cycle while the queue has room, one result per cycle
// out when ready; a four-entry queue between classifier and emitter absorbs stalls
// reset: count, byte phase, queue and output stage cleared, modulus 3329, target 64
module uniform_rejection_sampler_12bit_core (
	input  logic      clk,
	input  logic      arst_n,
	urs_in_if.sink    smp_in,
	urs_out_if.source smp_out,
	urs_cfg_if.sink   cfg
);
	import urs_pkg::*;

	logic [MOD_W-1:0]   modulus_q;
	logic [COUNT_W-1:0] target_q;
	urs_cfg_t           cfg_eff;
	urs_entry_t         push_entry, pop_entry;
	urs_fifo_status_t   fifo_st;
	logic               push, pop;

	// register writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
			target_q  <= TARGET_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MODULUS) modulus_q <= cfg.wdata[MOD_W-1:0];
			if (cfg.index == REG_TARGET)  target_q  <= cfg.wdata[COUNT_W-1:0];
		end
	end

	// target is clamped to the polynomial length
	assign cfg_eff.modulus = modulus_q;
	assign cfg_eff.target  = (target_q > MAX_COUNT) ? MAX_COUNT : target_q;

	// front: byte grouping, candidate compare and count tracking
	urs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp_in     (smp_in),
		.cfg        (cfg_eff),
		.fifo_st    (fifo_st),
		.push       (push),
		.push_entry (push_entry)
	);

	// queue of groups holding one or two accepted coefficients
	urs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.status     (fifo_st)
	);

	// back: serializes each group onto the output, one coefficient per cycle while ready
	urs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_entry (pop_entry),
		.fifo_st   (fifo_st),
		.pop       (pop),
		.smp_out   (smp_out)
	);

endmodule
